FILE: hdl/hmcpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hmcpd_pkg;

  // heatmap geometry
  localparam int MAP_WIDTH  = 96;
  localparam int MAP_HEIGHT = 72;

  // counter and address widths
  localparam int COL_W   = $clog2(MAP_WIDTH);
  localparam int ROW_W   = $clog2(MAP_HEIGHT + 1);
  localparam int COORD_W = (COL_W > ROW_W) ? COL_W : ROW_W;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int OUTC_W   = 12;
  localparam int COUNT_W  = 16;
  localparam int MAP_W    = 5;
  localparam int SCALE_W  = 5;
  localparam int MAPS_W   = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [OUTC_W-1:0]  OUTC_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [MAP_W-1:0]   MAP_MAX   = '1;

  // command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PEAK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAPS     = 2'd2;

  // configuration reset values
  localparam logic signed [SAMPLE_W-1:0] MIN_PEAK_RST = 16'sd1229;
  localparam logic [SCALE_W-1:0]         SCALE_RST    = 5'd4;
  localparam logic [MAPS_W-1:0]          MAPS_RST     = 6'd14;

  typedef struct packed {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample_value;
  } in_word_t;

  typedef struct packed {
    logic [OUTC_W-1:0]          peak_row;
    logic [OUTC_W-1:0]          peak_col;
    logic signed [SAMPLE_W-1:0] peak_score;
    logic [COUNT_W-1:0]         peak_number;
    logic [MAP_W-1:0]           joint_type;
  } out_word_t;

  // one line store entry: the last row and the row before it, same column
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] cur;
    logic signed [SAMPLE_W-1:0] prv;
  } line_pair_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    line_pair_t       data;
  } line_wr_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
  } line_rd_t;

  // p*s + floor((s-1)/2), zero scale gives zero, clipped at the top
  function automatic logic [OUTC_W-1:0] scale_coord(input logic [COORD_W-1:0] p,
                                                    input logic [SCALE_W-1:0] s);
    logic [COORD_W+SCALE_W:0] v;
    v = (COORD_W + SCALE_W + 1)'(p * s) + (COORD_W + SCALE_W + 1)'((s - 5'd1) >> 1);
    if (s == '0) begin
      scale_coord = '0;
    end else if (v > (COORD_W + SCALE_W + 1)'(OUTC_MAX)) begin
      scale_coord = OUTC_MAX;
    end else begin
      scale_coord = v[OUTC_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/hmcpd_line_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module hmcpd_line_ram (
  input  wire                  clk,
  input  hmcpd_pkg::line_wr_t  wr,
  input  hmcpd_pkg::line_rd_t  rd,
  output hmcpd_pkg::line_pair_t rd_data
);
  import hmcpd_pkg::*;

  line_pair_t mem [MAP_WIDTH];
  line_pair_t rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hdl/heatmap_cross_peak_detector.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_word   (cmd, sample_value)
// out      output     out_valid / out_ready  out_word  (row, col, score, number, joint)
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one word per cycle while ready; a peak is buffered when the word below it is accepted
// the line store is one ram of MAP_WIDTH entries, each holding two rows of a column,
// read two columns ahead so its single registered read port keeps up every cycle
// synchronous reset clears position, counters and output valids; no clearing pass
// a two-entry output buffer lets input run while a result waits; ready drops when full

module heatmap_cross_peak_detector (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  hmcpd_pkg::in_word_t                  in_word,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output hmcpd_pkg::out_word_t                 out_word,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [hmcpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [hmcpd_pkg::SAMPLE_W-1:0]        cfg_data
);
  import hmcpd_pkg::*;

  // configuration registers
  logic signed [SAMPLE_W-1:0] min_peak_r;
  logic [SCALE_W-1:0]         scale_r;
  logic [MAPS_W-1:0]          maps_r;

  // position and counters
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [MAP_W-1:0]   map_r, map_nxt;
  logic [COUNT_W-1:0] peak_cnt_r, peak_cnt_nxt;
  logic signed [SAMPLE_W-1:0] left_r, left_nxt;

  // window: entry of the current column; ram output holds the next column
  line_pair_t win_r;
  line_pair_t rd_data;
  line_wr_t   wr;
  line_rd_t   rd;

  // output buffer
  out_word_t head_r, skid_r;
  logic      head_v_r, skid_v_r;

  logic accept, sample_phase, act, decide_en, peak, push, pop;
  logic has_up, has_left, has_right, last_col, map_end;
  logic signed [SAMPLE_W-1:0] center;
  logic [ROW_W-1:0]   drow;
  logic [COL_W:0]     col_plus2;
  out_word_t          new_word;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_v_r;
  assign out_valid = head_v_r;
  assign out_word  = head_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_peak_r <= MIN_PEAK_RST;
      scale_r    <= SCALE_RST;
      maps_r     <= MAPS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_PEAK: min_peak_r <= cfg_data;
        CFG_SCALE:    scale_r    <= cfg_data[SCALE_W-1:0];
        CFG_MAPS:     maps_r     <= cfg_data[MAPS_W-1:0];
        default:      ;
      endcase
    end
  end

  // step control
  assign accept       = in_valid && in_ready;
  assign sample_phase = row_r < ROW_W'(MAP_HEIGHT);
  assign act          = accept && !(sample_phase && (in_word.cmd == CMD_FLUSH));
  assign decide_en    = act && (!sample_phase || (row_r != '0));
  assign drow         = row_r - ROW_W'(1);
  assign last_col     = col_r == COL_W'(MAP_WIDTH - 1);

  // cross compare on the decided centre
  assign center    = win_r.cur;
  assign has_up    = row_r >= ROW_W'(2);
  assign has_left  = col_r != '0;
  assign has_right = !last_col;

  always_comb begin
    peak = center > min_peak_r;
    if (has_up && (center < win_r.prv)) peak = 1'b0;
    if (has_left && (center < left_r)) peak = 1'b0;
    if (has_right && (center < rd_data.cur)) peak = 1'b0;
    if (sample_phase && (center < in_word.sample_value)) peak = 1'b0;
  end

  assign push = decide_en && peak;
  assign pop  = head_v_r && out_ready;

  always_comb begin
    new_word.peak_row    = scale_coord(COORD_W'(drow), scale_r);
    new_word.peak_col    = scale_coord(COORD_W'(col_r), scale_r);
    new_word.peak_score  = center;
    new_word.peak_number = peak_cnt_r;
    new_word.joint_type  = map_r;
  end

  // line store access: write the current column, prefetch two columns ahead
  assign col_plus2 = {1'b0, col_r} + (COL_W + 1)'(2);

  always_comb begin
    wr.en     = act && sample_phase;
    wr.addr   = col_r;
    wr.data.cur = in_word.sample_value;
    wr.data.prv = win_r.cur;
    rd.en     = act;
    if (col_plus2 >= (COL_W + 1)'(MAP_WIDTH)) begin
      rd.addr = COL_W'(col_plus2 - (COL_W + 1)'(MAP_WIDTH));
    end else begin
      rd.addr = col_plus2[COL_W-1:0];
    end
  end

  hmcpd_line_ram u_line_ram (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (act) begin
      win_r <= rd_data;
    end
  end

  // position, map and peak counters
  assign map_end = (({1'b0, map_r} + MAPS_W'(1)) >= maps_r) || (map_r == MAP_MAX);

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    map_nxt      = map_r;
    peak_cnt_nxt = peak_cnt_r;
    left_nxt     = left_r;
    if (decide_en) begin
      left_nxt = center;
    end
    if (push && (peak_cnt_r != COUNT_MAX)) begin
      peak_cnt_nxt = peak_cnt_r + COUNT_W'(1);
    end
    if (act) begin
      if (last_col) begin
        col_nxt = '0;
        if (sample_phase) begin
          row_nxt = row_r + ROW_W'(1);
        end else begin
          row_nxt = '0;
          if (map_end) begin
            map_nxt      = '0;
            peak_cnt_nxt = '0;
          end else begin
            map_nxt = map_r + MAP_W'(1);
          end
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      map_r      <= '0;
      peak_cnt_r <= '0;
      left_r     <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      map_r      <= map_nxt;
      peak_cnt_r <= peak_cnt_nxt;
      left_r     <= left_nxt;
    end
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_v_r) begin
          skid_v_r <= 1'b0;
        end else begin
          head_v_r <= push;
        end
      end else if (push) begin
        if (head_v_r) begin
          skid_v_r <= 1'b1;
        end else begin
          head_v_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_v_r) begin
        head_r <= skid_r;
      end else if (push) begin
        head_r <= new_word;
      end
    end else if (push) begin
      if (head_v_r) begin
        skid_r <= new_word;
      end else begin
        head_r <= new_word;
      end
    end
  end

endmodule

`default_nettype wire
